// ===== rtl/leverage_residual_reweight_assert.svh =====
// Assertion macros for the leverage residual reweighting block.
`ifndef LEVERAGE_RESIDUAL_REWEIGHT_ASSERT_SVH
`define LEVERAGE_RESIDUAL_REWEIGHT_ASSERT_SVH
`ifndef SYNTHESIS
`define LRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LRR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LRR_ASSERT(lbl, prop, msg)
`define LRR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/lrr_pkg.sv =====
// Shared types, constants and helper functions of the leverage reweighting block.
package lrr_pkg;

  localparam int unsigned DIV_NUM_W = 112;
  localparam int unsigned DIV_DEN_W = 72;
  localparam int unsigned ACC_W     = 128;
  localparam int unsigned COV_N     = 21;

  localparam logic [63:0] SEED_COV = 64'd1099511627776000000;
  localparam logic [24:0] DISC_ONE = 25'd16777216;
  localparam logic [24:0] DISC_MIN = 25'd16777;

  typedef logic [4:0] cov_addr_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        reseed;
    logic        we;
    cov_addr_t   addr;
    logic [63:0] data;
  } cov_wr_t;

  // Packed upper-triangle index of element (r, c) of the symmetric matrix.
  function automatic cov_addr_t pack_idx(logic [2:0] r, logic [2:0] c);
    logic [2:0] lo;
    logic [2:0] hi;
    cov_addr_t  base;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    case (lo)
      3'd0:    base = 5'd0;
      3'd1:    base = 5'd6;
      3'd2:    base = 5'd11;
      3'd3:    base = 5'd15;
      3'd4:    base = 5'd18;
      default: base = 5'd20;
    endcase
    return base + 5'(hi - lo);
  endfunction

  function automatic logic is_diag(cov_addr_t p);
    return p inside {5'd0, 5'd6, 5'd11, 5'd15, 5'd18, 5'd20};
  endfunction

  // One 32-bit half of a 64-bit word as a signed 33-bit multiplier operand.
  function automatic logic [32:0] half33(logic [63:0] v, logic upper);
    return upper ? {v[63], v[63:32]} : {1'b0, v[31:0]};
  endfunction

endpackage

// ===== rtl/lrr_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
module lrr_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/lrr_div.sv =====
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module lrr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrr_pkg::div_req_t req_i,
  output lrr_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = lrr_pkg::DIV_NUM_W;
  localparam int unsigned DW = lrr_pkg::DIV_DEN_W;

  logic          busy_q;
  logic          done_q;
  logic [6:0]    cnt_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_nx;

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'(NW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= rem_nx[DW-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ===== rtl/lrr_cov_store.sv =====
// Packed upper-triangle covariance store with reseed and one write port.
module lrr_cov_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrr_pkg::cov_wr_t   wr_i,
  input  lrr_pkg::cov_addr_t rd_addr_i,
  output logic [63:0]        rd_data_o
);

  logic [63:0] cov_q [lrr_pkg::COV_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < lrr_pkg::COV_N; n++) begin
        cov_q[n] <= lrr_pkg::is_diag(5'(n)) ? lrr_pkg::SEED_COV : 64'd0;
      end
    end else if (wr_i.reseed) begin
      for (int n = 0; n < lrr_pkg::COV_N; n++) begin
        cov_q[n] <= lrr_pkg::is_diag(5'(n)) ? lrr_pkg::SEED_COV : 64'd0;
      end
    end else if (wr_i.we) begin
      cov_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = cov_q[rd_addr_i];

endmodule

// ===== rtl/leverage_residual_reweight.sv =====
// Top level of the leverage residual reweighting block.
//
// Each input transaction carries one plane residual: a six-element Jacobian
// row (Q16.16), a variance and a plane variance term (Q8.24). The block keeps
// a symmetric 6x6 covariance (Q24.40, packed upper triangle, 21 entries) that
// is reseeded to 1.0e6 times identity when tuser (frame start) is set. With
// the mode register at 1 and a positive variance it forms s = S*j and
// q = j.s, derives the discount 1/(1 + q/variance) clamped to [0.001, 1.0],
// divides the variance, and the plane variance term if positive, by it and
// downdates S by s*s^T / (variance + q) if that divisor is positive.
// Otherwise the residual passes through with a discount of 1.0 and tuser
// low on the output. All arithmetic of a reweighted one runs on one 33x33
// multiplier (168 partial products in all) and one bit-serial divider that
// is used up to 25 times, 21 of them in the covariance downdate. The input
// is not ready while an item is being worked on; a finished result waits in
// an output register, so the next item can be accepted before it is taken.
// The mode register is written through cfg_valid_i/cfg_data_i; the user
// must write it only while the block is idle, the block does not enforce it.
`include "leverage_residual_reweight_assert.svh"

module leverage_residual_reweight (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: mode register.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, lowest bit up: rot_x, rot_y, rot_z, norm_x, norm_y, norm_z,
  // variance_in, plane_var_in (32 bits each).
  input  logic [255:0] s_axis_tdata,
  // tuser: frame_start.
  input  logic         s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, lowest bit up: variance_out (48), plane_var_out (48),
  // discount (25), seven zero bits.
  output logic [127:0] m_axis_tdata,
  // tuser: touched.
  output logic         m_axis_tuser
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_S_MUL, ST_S_ACC, ST_S_STORE, ST_Q_MUL, ST_Q_ACC,
    ST_LEV, ST_LEV_WAIT, ST_DEN, ST_DISC_WAIT, ST_VAR, ST_VAR_WAIT,
    ST_PV, ST_PV_WAIT, ST_DD_CHECK, ST_DD_LOAD, ST_DD_MUL, ST_DD_ACC,
    ST_DD_DIV, ST_DD_WAIT, ST_FINISH
  } state_e;

  state_e       state_q;
  logic         mode_q;
  logic [2:0]   i_q;
  logic [2:0]   k_q;
  logic [1:0]   pc_q;
  logic [31:0]  j_q [6];
  logic [63:0]  s_q [6];
  logic [63:0]  si_q;
  logic [31:0]  var_q;
  logic [31:0]  pv_q;
  logic [127:0] acc_q;
  logic [99:0]  q_q;
  logic [63:0]  den_q;
  logic [24:0]  disc_q;
  logic [71:0]  dd_q;
  logic         nneg_q;
  logic [47:0]  var_res_q;
  logic [47:0]  pv_res_q;
  logic         touched_q;
  logic         out_valid_q;
  logic [127:0] out_data_q;
  logic         out_user_q;

  logic                accept;
  logic [2:0]          j_idx;
  logic [2:0]          s_idx;
  logic [31:0]         jv;
  logic [63:0]         sv;
  lrr_pkg::cov_addr_t  cov_addr;
  logic [63:0]         cov_rd;
  lrr_pkg::cov_wr_t    cov_wr;
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  prod;
  logic [1:0]          sh;
  logic [127:0]        prod_ext;
  logic [127:0]        addend;
  logic [127:0]        acc_sum;
  logic [63:0]         s_sat;
  logic [99:0]         q_mag;
  logic [111:0]        quot;
  logic [62:0]         lev_mag;
  logic [63:0]         lev;
  logic [24:0]         disc_clamped;
  logic [67:0]         dd_calc;
  logic [111:0]        numv;
  logic [111:0]        nabs;
  logic [113:0]        diff;
  logic [63:0]         cov_new;
  logic                den_pos;
  logic                pass;
  lrr_pkg::div_req_t   div_req;
  lrr_pkg::div_rsp_t   div_rsp;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign pass = !mode_q || $signed(s_axis_tdata[223:192]) <= 32'sd0;

  // Single read index into each of the small operand arrays.
  assign j_idx    = (state_q == ST_S_MUL) ? k_q : i_q;
  assign s_idx    = (state_q == ST_DD_MUL) ? k_q : i_q;
  assign jv       = j_q[j_idx];
  assign sv       = s_q[s_idx];
  assign cov_addr = lrr_pkg::pack_idx(i_q, k_q);

  always_comb begin
    case (state_q)
      ST_S_MUL: begin
        mul_a = lrr_pkg::half33(cov_rd, pc_q[0]);
        mul_b = {jv[31], jv};
      end
      ST_Q_MUL: begin
        mul_a = lrr_pkg::half33(sv, pc_q[0]);
        mul_b = {jv[31], jv};
      end
      default: begin
        mul_a = lrr_pkg::half33(si_q, pc_q[1]);
        mul_b = lrr_pkg::half33(sv, pc_q[0]);
      end
    endcase
  end

  lrr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Partial products are weighted by 2^32 per upper half taken.
  assign sh       = (state_q == ST_DD_ACC) ? ({1'b0, pc_q[1]} + {1'b0, pc_q[0]})
                                           : {1'b0, pc_q[0]};
  assign prod_ext = {{62{prod[65]}}, prod};

  always_comb begin
    case (sh)
      2'd0:    addend = prod_ext;
      2'd1:    addend = {prod_ext[95:0], 32'd0};
      default: addend = {prod_ext[63:0], 64'd0};
    endcase
  end

  assign acc_sum = acc_q + addend;

  // s_i is the accumulated sum shifted down by 16 and saturated to 64 bits.
  assign s_sat = ((&acc_q[127:79]) || !(|acc_q[127:79])) ? acc_q[79:16]
               : (acc_q[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

  assign q_mag = q_q[99] ? (100'd0 - q_q) : q_q;
  assign quot  = div_rsp.quot;

  // Leverage magnitude clamps at 2^62, then takes the sign of q.
  assign lev_mag = (quot > (112'd1 << 62)) ? (63'd1 << 62) : quot[62:0];
  assign lev     = q_q[99] ? (64'd0 - {1'b0, lev_mag}) : {1'b0, lev_mag};
  assign den_pos = !den_q[63] && (|den_q);

  assign disc_clamped = (quot >= 112'(lrr_pkg::DISC_ONE)) ? lrr_pkg::DISC_ONE
                      : (quot < 112'(lrr_pkg::DISC_MIN)) ? lrr_pkg::DISC_MIN
                      : quot[24:0];

  assign dd_calc = {{36{var_q[31]}}, var_q} + q_q[99:32];

  assign numv = acc_q[127:16];
  assign nabs = numv[111] ? (112'd0 - numv) : numv;

  // New entry: S minus the signed quotient, saturated to 64 bits.
  assign diff    = {{50{cov_rd[63]}}, cov_rd}
                 + (nneg_q ? {2'b00, quot} : (114'd0 - {2'b00, quot}));
  assign cov_new = ((&diff[113:63]) || !(|diff[113:63])) ? diff[63:0]
                 : (diff[113] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

  always_comb begin
    div_req = '0;
    case (state_q)
      ST_LEV: begin
        div_req.start = 1'b1;
        div_req.num   = 112'(q_mag);
        div_req.den   = 72'(var_q[30:0]);
      end
      ST_DEN: begin
        div_req.start = den_pos;
        div_req.num   = 112'd1 << 56;
        div_req.den   = 72'(den_q[62:0]);
      end
      ST_VAR: begin
        div_req.start = 1'b1;
        div_req.num   = 112'({var_q[30:0], 24'd0});
        div_req.den   = 72'(disc_q);
      end
      ST_PV: begin
        div_req.start = 1'b1;
        div_req.num   = 112'({pv_q[30:0], 24'd0});
        div_req.den   = 72'(disc_q);
      end
      ST_DD_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = nabs;
        div_req.den   = dd_q;
      end
      default: div_req = '0;
    endcase
  end

  lrr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cov_wr.reseed = accept && s_axis_tuser;
  assign cov_wr.we     = (state_q == ST_DD_WAIT) && div_rsp.done;
  assign cov_wr.addr   = cov_addr;
  assign cov_wr.data   = cov_new;

  lrr_cov_store u_cov (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cov_wr),
    .rd_addr_i (cov_addr),
    .rd_data_o (cov_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      // In the finishing state the output register is reloaded below instead.
      if (out_valid_q && m_axis_tready && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            for (int n = 0; n < 6; n++) begin
              j_q[n] <= s_axis_tdata[32*n +: 32];
            end
            var_q     <= s_axis_tdata[223:192];
            pv_q      <= s_axis_tdata[255:224];
            var_res_q <= {{16{s_axis_tdata[223]}}, s_axis_tdata[223:192]};
            pv_res_q  <= {{16{s_axis_tdata[255]}}, s_axis_tdata[255:224]};
            disc_q    <= lrr_pkg::DISC_ONE;
            touched_q <= !pass;
            acc_q     <= '0;
            i_q       <= '0;
            k_q       <= '0;
            pc_q      <= '0;
            state_q   <= pass ? ST_FINISH : ST_S_MUL;
          end
        end
        ST_S_MUL: state_q <= ST_S_ACC;
        ST_S_ACC: begin
          acc_q <= acc_sum;
          if (!pc_q[0]) begin
            pc_q    <= 2'd1;
            state_q <= ST_S_MUL;
          end else begin
            pc_q <= 2'd0;
            if (k_q == 3'd5) begin
              state_q <= ST_S_STORE;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_S_MUL;
            end
          end
        end
        ST_S_STORE: begin
          s_q[i_q] <= s_sat;
          acc_q    <= '0;
          k_q      <= '0;
          if (i_q == 3'd5) begin
            i_q     <= '0;
            state_q <= ST_Q_MUL;
          end else begin
            i_q     <= i_q + 3'd1;
            state_q <= ST_S_MUL;
          end
        end
        ST_Q_MUL: state_q <= ST_Q_ACC;
        ST_Q_ACC: begin
          acc_q <= acc_sum;
          if (!pc_q[0]) begin
            pc_q    <= 2'd1;
            state_q <= ST_Q_MUL;
          end else begin
            pc_q <= 2'd0;
            if (i_q == 3'd5) begin
              q_q     <= acc_sum[99:0];
              state_q <= ST_LEV;
            end else begin
              i_q     <= i_q + 3'd1;
              state_q <= ST_Q_MUL;
            end
          end
        end
        ST_LEV: state_q <= ST_LEV_WAIT;
        ST_LEV_WAIT: begin
          if (div_rsp.done) begin
            den_q   <= lev + 64'h1_0000_0000;
            state_q <= ST_DEN;
          end
        end
        ST_DEN: begin
          if (den_pos) begin
            state_q <= ST_DISC_WAIT;
          end else begin
            disc_q  <= lrr_pkg::DISC_MIN;
            state_q <= ST_VAR;
          end
        end
        ST_DISC_WAIT: begin
          if (div_rsp.done) begin
            disc_q  <= disc_clamped;
            state_q <= ST_VAR;
          end
        end
        ST_VAR: state_q <= ST_VAR_WAIT;
        ST_VAR_WAIT: begin
          if (div_rsp.done) begin
            var_res_q <= quot[47:0];
            state_q   <= ($signed(pv_q) > 32'sd0) ? ST_PV : ST_DD_CHECK;
          end
        end
        ST_PV: state_q <= ST_PV_WAIT;
        ST_PV_WAIT: begin
          if (div_rsp.done) begin
            pv_res_q <= quot[47:0];
            state_q  <= ST_DD_CHECK;
          end
        end
        ST_DD_CHECK: begin
          dd_q <= 72'(dd_calc[66:0]);
          i_q  <= '0;
          k_q  <= '0;
          // A divisor that is not positive leaves the covariance untouched.
          state_q <= (!dd_calc[67] && (|dd_calc)) ? ST_DD_LOAD : ST_FINISH;
        end
        ST_DD_LOAD: begin
          si_q    <= sv;
          acc_q   <= '0;
          pc_q    <= '0;
          state_q <= ST_DD_MUL;
        end
        ST_DD_MUL: state_q <= ST_DD_ACC;
        ST_DD_ACC: begin
          acc_q <= acc_sum;
          if (pc_q == 2'd3) begin
            state_q <= ST_DD_DIV;
          end else begin
            pc_q    <= pc_q + 2'd1;
            state_q <= ST_DD_MUL;
          end
        end
        ST_DD_DIV: begin
          nneg_q  <= numv[111];
          state_q <= ST_DD_WAIT;
        end
        ST_DD_WAIT: begin
          if (div_rsp.done) begin
            if (k_q == 3'd5) begin
              if (i_q == 3'd5) begin
                state_q <= ST_FINISH;
              end else begin
                i_q     <= i_q + 3'd1;
                k_q     <= i_q + 3'd1;
                state_q <= ST_DD_LOAD;
              end
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_DD_LOAD;
            end
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {7'd0, disc_q, pv_res_q, var_res_q};
            out_user_q  <= touched_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `LRR_ASSERT(a_disc_range,
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[120:96] >= lrr_pkg::DISC_MIN
      && m_axis_tdata[120:96] <= lrr_pkg::DISC_ONE),
    "discount of a reweighted result out of range")
  `LRR_ASSERT(a_pass_disc,
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[120:96] == lrr_pkg::DISC_ONE),
    "pass-through result without unit discount")
  `LRR_ASSERT(a_div_idle, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `LRR_ASSERT_RST(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "output valid during reset")

endmodule

// ===== test/lrr_checker.sv =====
// Checker for the leverage reweighting block: covariance predictor and result comparison.
module lrr_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic         cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [255:0] s_tdata_i,
  input  logic         s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [127:0] m_tdata_i,
  input  logic         m_tuser_i,
  output int           mismatches_o,
  output int           outstanding_o
);

  typedef struct packed {
    logic [47:0] variance;
    logic [47:0] plane_var;
    logic [24:0] discount;
    logic        touched;
  } weight_t;

  localparam int TRI_BASE [6] = '{0, 6, 11, 15, 18, 20};
  localparam logic signed [127:0] LEV_CAP = 128'sh4000000000000000;

  logic signed [63:0] cov_q [lrr_pkg::COV_N];
  logic               gain_mode;
  weight_t            weights_q [$];
  int                 mismatches;

  assign mismatches_o  = mismatches;
  assign outstanding_o = weights_q.size();

  function automatic int tri_idx(int r, int c);
    return (r <= c) ? TRI_BASE[r] + c - r : TRI_BASE[c] + r - c;
  endfunction

  function automatic logic signed [63:0] sat64(logic signed [127:0] x);
    if (&x[127:63] || ~|x[127:63]) return x[63:0];
    return x[127] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
  endfunction

  task automatic reseed_cov();
    for (int n = 0; n < lrr_pkg::COV_N; n++) cov_q[n] = 64'sd0;
    for (int n = 0; n < 6; n++) cov_q[tri_idx(n, n)] = lrr_pkg::SEED_COV;
  endtask

  // Works out the expected result of one residual and applies the downdate to a reweighted one.
  task automatic reweight_residual(input logic frame, input logic [255:0] d,
                                   output weight_t w);
    logic signed [63:0]  jac [6];
    logic signed [63:0]  proj [6];
    logic signed [63:0]  var_s, pv_s, lev, den;
    logic signed [127:0] acc, q, lev_w, dd, num, upd;
    logic [63:0]         disc, scaled;
    if (frame) reseed_cov();
    var_s = $signed(d[223:192]);
    pv_s  = $signed(d[255:224]);
    if (!gain_mode || var_s <= 0) begin
      w.variance  = var_s[47:0];
      w.plane_var = pv_s[47:0];
      w.discount  = lrr_pkg::DISC_ONE;
      w.touched   = 1'b0;
      return;
    end
    for (int n = 0; n < 6; n++) jac[n] = $signed(d[32*n +: 32]);
    for (int r = 0; r < 6; r++) begin
      acc = 0;
      for (int c = 0; c < 6; c++) acc = acc + cov_q[tri_idx(r, c)] * jac[c];
      proj[r] = sat64(acc >>> 16);
    end
    q = 0;
    for (int n = 0; n < 6; n++) q = q + jac[n] * proj[n];
    // Leverage truncates toward zero and is capped at 2^62 either way.
    lev_w = q / var_s;
    if (lev_w > LEV_CAP) lev_w = LEV_CAP;
    if (lev_w < -LEV_CAP) lev_w = -LEV_CAP;
    lev = lev_w[63:0];
    den = lev + 64'sh100000000;
    if (den <= 0) begin
      disc = lrr_pkg::DISC_MIN;
    end else begin
      disc = (64'h1 << 56) / $unsigned(den);
      if (disc > lrr_pkg::DISC_ONE) disc = lrr_pkg::DISC_ONE;
      if (disc < lrr_pkg::DISC_MIN) disc = lrr_pkg::DISC_MIN;
    end
    scaled = $unsigned(var_s);
    scaled = (scaled << 24) / disc;
    w.variance = scaled[47:0];
    if (pv_s > 0) begin
      scaled = $unsigned(pv_s);
      scaled = (scaled << 24) / disc;
      w.plane_var = scaled[47:0];
    end else begin
      w.plane_var = pv_s[47:0];
    end
    w.discount = disc[24:0];
    w.touched  = 1'b1;
    // Sherman-Morrison downdate, skipped when the divisor is not positive.
    dd = var_s + (q >>> 32);
    if (dd > 0) begin
      for (int r = 0; r < 6; r++) begin
        for (int c = r; c < 6; c++) begin
          num = (proj[r] * proj[c]) >>> 16;
          upd = num / dd;
          acc = cov_q[tri_idx(r, c)];
          cov_q[tri_idx(r, c)] = sat64(acc - upd);
        end
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    gain_mode  = 1'b0;
    reseed_cov();
  end

  always @(posedge clk_i) begin
    weight_t w, seen;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) gain_mode = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        reweight_residual(s_tuser_i, s_tdata_i, w);
        weights_q.insert(weights_q.size(), w);
      end
      if (m_tvalid_i && m_tready_i) begin
        seen.variance  = m_tdata_i[47:0];
        seen.plane_var = m_tdata_i[95:48];
        seen.discount  = m_tdata_i[120:96];
        seen.touched   = m_tuser_i;
        if (weights_q.size() == 0) begin
          report("unexpected result", seen.variance, 64'd0);
        end else begin
          w = weights_q.pop_front();
          if (seen.variance !== w.variance) report("variance_out", seen.variance, w.variance);
          if (seen.plane_var !== w.plane_var)
            report("plane_var_out", seen.plane_var, w.plane_var);
          if (seen.discount !== w.discount) report("discount", seen.discount, w.discount);
          if (seen.touched !== w.touched) report("touched", seen.touched, w.touched);
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the leverage reweighting testbench: clock, reset, stimulus and verdict.
module testbench;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_data_i = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  int mismatches;
  int outstanding;

  // Stall controls shared between the sender and the receiver processes.
  logic steady_flow = 1'b0;
  logic hold_sink   = 1'b0;

  always #5 clk_i = ~clk_i;

  leverage_residual_reweight u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  lrr_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  // Receiver: random back-pressure, except during a steady stretch. On request it
  // holds tready low so that the block fills and stalls its input.
  always @(negedge clk_i) begin
    if (hold_sink) begin
      m_axis_tready = 1'b0;
      repeat (400) @(negedge clk_i);
      hold_sink = 1'b0;
    end
    m_axis_tready = steady_flow || ($urandom_range(0, 99) >= 32);
  end

  // This bound allows many times the slowest correct run.
  initial begin
    #400_000_000;
    $display("FAILURE");
    $finish;
  end

  // Sends one residual transaction, with random idle gaps in front of it outside a steady stretch.
  task automatic send_residual(input logic frame, input logic [31:0] jac [6],
                               input logic [31:0] variance, input logic [31:0] plane_var);
    while (!steady_flow && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = frame;
    s_axis_tdata  = {plane_var, variance, jac[5], jac[4], jac[3], jac[2], jac[1], jac[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // The mode register is only written once every expected result has been taken.
  task automatic write_mode(input logic gain);
    wait (outstanding == 0);
    repeat (8) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = gain;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] random_component();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      2:       return 32'h0;
      3:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [31:0] random_variance();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'($signed(-$urandom_range(0, 1000)));
      2:       return $urandom_range(1, 16);
      3:       return 32'h7fffffff;
      default: return $urandom_range(1 << 20, 1 << 28);
    endcase
  endfunction

  initial begin
    logic [31:0] jac [6];
    logic [31:0] fixed_row [6];
    int          frame_left;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: pass-through in mode 0, then the reweighting cases.
    jac = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff, 32'h80000000, 32'h00010000};
    send_residual(1'b1, jac, 32'h7fffffff, 32'h80000000);
    send_residual(1'b0, jac, 32'h80000000, 32'h7fffffff);
    write_mode(1'b1);
    // Zero Jacobian gives no leverage and the full discount.
    jac = '{default: 32'h0};
    send_residual(1'b1, jac, 32'h01000000, 32'h01000000);
    // Large leverage pushes the discount to its floor.
    jac = '{default: 32'h7fffffff};
    send_residual(1'b1, jac, 32'h00000001, 32'h7fffffff);
    jac = '{default: 32'h80000000};
    send_residual(1'b1, jac, 32'h7fffffff, 32'h00000001);
    // Non-positive variance passes through even in mode 1; a non-positive plane term is left unscaled.
    send_residual(1'b0, jac, 32'h00000000, 32'h00100000);
    send_residual(1'b0, jac, 32'hffffffff, 32'h00100000);
    send_residual(1'b0, jac, 32'h01000000, 32'h00000000);
    send_residual(1'b0, jac, 32'h01000000, 32'h80000000);
    // Repeating one row drives the covariance towards singularity, where rounding
    // can make the leverage or the downdate divisor turn negative.
    fixed_row = '{32'h00010000, 32'hffff0000, 32'h00008000, 32'h00020000,
                  32'h00000100, 32'hfffe0000};
    send_residual(1'b1, fixed_row, 32'h00000010, 32'h00000010);
    for (int n = 0; n < 10; n++) send_residual(1'b0, fixed_row, 32'h00000001 << n, 32'h1);
    jac = '{32'h12345678, 32'hedcba987, 32'h0000ffff, 32'hffff0001, 32'h55555555, 32'haaaaaaaa};
    send_residual(1'b0, jac, 32'h00010000, 32'hfff00000);
    send_residual(1'b0, jac, 32'h00000002, 32'h00000003);

    // Random part in four phases of alternating mode, frames of random length.
    // The long receiver hold falls in a pass-through phase, where transactions
    // are short enough for the block to fill and stall its input.
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase[0] ? 1'b1 : 1'b0);
      steady_flow = (phase == 2);
      if (phase == 0) hold_sink = 1'b1;
      frame_left = 0;
      for (int n = 0; n < 250; n++) begin
        for (int c = 0; c < 6; c++) jac[c] = random_component();
        if (frame_left == 0) frame_left = $urandom_range(1, 12);
        send_residual(frame_left == $urandom_range(1, 12) || n == 0, jac,
                      random_variance(), random_variance());
        frame_left--;
        // Sender pauses until the pipeline drains.
        if (n == 120) wait (outstanding == 0);
      end
      steady_flow = 1'b0;
    end

    wait (outstanding == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== leverage_residual_reweight.f =====
+incdir+rtl
rtl/lrr_pkg.sv
rtl/lrr_mul.sv
rtl/lrr_div.sv
rtl/lrr_cov_store.sv
rtl/leverage_residual_reweight.sv
test/lrr_checker.sv
test/testbench.sv
